// ===== design/at_command_line_parser_defines.svh =====
// Assertion macros shared by the AT command line parser modules.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef AT_COMMAND_LINE_PARSER_DEFINES_SVH
`define AT_COMMAND_LINE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks an implication property on every rising clock edge outside reset.
`define ATCLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds on a rising clock edge outside reset.
`define ATCLP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ATCLP_ASSERT(lbl, prop, msg)
`define ATCLP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/atclp_pkg.sv =====
// Shared types, character constants and helper functions of the AT command line parser.
// No dependencies.
package atclp_pkg;

    localparam int NAME_LIMIT_DEF = 32;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [3:0] {
        PH_A,
        PH_T,
        PH_WS1,
        PH_NAME,
        PH_WS2,
        PH_EQWS,
        PH_QWS,
        PH_ARGS,
        PH_IGNORE
    } phase_t;

    typedef enum logic [1:0] {
        CMD_EXEC = 2'd0,
        CMD_READ = 2'd1,
        CMD_TEST = 2'd2,
        CMD_SET  = 2'd3
    } cmd_class_t;

    typedef enum logic [1:0] {
        CK_NONE = 2'd0,
        CK_NAME = 2'd1,
        CK_ARG  = 2'd2
    } char_kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [1:0] char_kind;
        logic [7:0] char_value;
        logic       done_res;
        logic       status;
        logic [1:0] cmd_class;
    } out_item_t;

    // Pipeline control between the result stage and the stages in front of it.
    typedef struct packed {
        logic move;     // the input register hands its transaction on this cycle
        logic blocked;  // the result register is full and stalled downstream
    } link_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

// ===== design/atclp_in_stage.sv =====
// Input register of the AT command line parser: holds one character transaction.
// Depends on atclp_pkg.
module atclp_in_stage
    import atclp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    output logic     stall,
    input  in_item_t data,
    input  link_t    link,
    output logic     vld_reg,
    output in_item_t item_reg
);

    logic take;
    logic vld_next;

    // The register can refill in the same cycle that it hands its content on.
    assign stall = vld_reg && link.blocked;
    assign take  = valid && !stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (link.move)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= data;
        end
    end

endmodule

// ===== design/atclp_parser.sv =====
// Line state machine of the AT command line parser: classifies one character per step.
// Depends on atclp_pkg and at_command_line_parser_defines.svh.
`include "at_command_line_parser_defines.svh"
module atclp_parser
    import atclp_pkg::*;
#(
    parameter int NAME_LIMIT = NAME_LIMIT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t res
);

    localparam int CNT_W = $clog2(NAME_LIMIT + 1);

    phase_t     phase_reg, phase_next, upd_phase;
    cmd_class_t kind_reg, kind_next, upd_kind;
    logic [CNT_W-1:0] count_reg, count_next, upd_count;
    logic       failed_reg, failed_next, upd_failed;

    logic [7:0] c;
    logic       ws;
    logic       delim;
    logic [CNT_W-1:0] cnt_inc;
    logic       name_full;
    logic       take_name;
    char_kind_t emit;
    char_kind_t name_emit;
    logic       err;
    logic       line_idle;

    assign c         = item.ch;
    assign ws        = is_ws(c);
    assign delim     = ws || (c == CH_EQ) || (c == CH_QUEST);
    assign cnt_inc   = count_reg + CNT_W'(1);
    assign name_full = (cnt_inc >= CNT_W'(NAME_LIMIT));
    assign line_idle = (phase_reg == PH_A) && (count_reg == '0) && !failed_reg
                       && (kind_reg == CMD_EXEC);

    // Effect of this character on the line state, before the end-of-line clear.
    always_comb
    begin
        upd_phase  = phase_reg;
        upd_kind   = kind_reg;
        upd_count  = count_reg;
        upd_failed = failed_reg;
        take_name  = 1'b0;
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_A:
                begin
                    if (c == CH_A) upd_phase = PH_T; else upd_failed = 1'b1;
                end
                PH_T:
                begin
                    if (c == CH_T) upd_phase = PH_WS1; else upd_failed = 1'b1;
                end
                PH_WS1:
                begin
                    if (c == CH_PLUS)
                    begin
                        upd_phase = PH_NAME;
                    end
                    else if (!ws)
                    begin
                        take_name = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    take_name = 1'b1;
                end
                PH_WS2:
                begin
                    if (c == CH_EQ)
                    begin
                        upd_kind  = CMD_SET;
                        upd_phase = PH_EQWS;
                    end
                    else if (c == CH_QUEST)
                    begin
                        upd_kind  = CMD_READ;
                        upd_phase = PH_QWS;
                    end
                    else if (!ws)
                    begin
                        upd_phase = PH_IGNORE;
                    end
                end
                PH_EQWS:
                begin
                    if (c == CH_QUEST)
                    begin
                        upd_kind  = CMD_TEST;
                        upd_phase = PH_IGNORE;
                    end
                    else if (!ws)
                    begin
                        upd_phase = PH_ARGS;
                    end
                end
                PH_QWS:
                begin
                    if (!ws)
                    begin
                        upd_kind  = CMD_SET;
                        upd_phase = PH_ARGS;
                    end
                end
                PH_ARGS:
                begin
                    if (is_eol(c)) upd_phase = PH_IGNORE;
                end
                default:
                begin
                    upd_phase = phase_reg;
                end
            endcase

            if (take_name)
            begin
                if (delim)
                begin
                    if (count_reg == '0)
                    begin
                        upd_failed = 1'b1;
                    end
                    else if (c == CH_EQ)
                    begin
                        upd_kind  = CMD_SET;
                        upd_phase = PH_EQWS;
                    end
                    else if (c == CH_QUEST)
                    begin
                        upd_kind  = CMD_READ;
                        upd_phase = PH_QWS;
                    end
                    else
                    begin
                        upd_phase = PH_WS2;
                    end
                end
                else
                begin
                    upd_count = cnt_inc;
                    if (name_full) upd_failed = 1'b1; else upd_phase = PH_NAME;
                end
            end
        end
    end

    // Next state: the last character of a line returns everything to reset values.
    always_comb
    begin
        if (item.last)
        begin
            phase_next  = PH_A;
            kind_next   = CMD_EXEC;
            count_next  = '0;
            failed_next = 1'b0;
        end
        else
        begin
            phase_next  = upd_phase;
            kind_next   = upd_kind;
            count_next  = upd_count;
            failed_next = upd_failed;
        end
    end

    // Outputs: tagged character and, on the last character, status and type.
    always_comb
    begin
        if (delim)
        begin
            name_emit = ((c == CH_QUEST) && (count_reg != '0)) ? CK_ARG : CK_NONE;
        end
        else
        begin
            name_emit = name_full ? CK_NONE : CK_NAME;
        end

        emit = CK_NONE;
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_WS1:  emit = (!ws && (c != CH_PLUS)) ? name_emit : CK_NONE;
                PH_NAME: emit = name_emit;
                PH_WS2:  emit = (c == CH_QUEST) ? CK_ARG : CK_NONE;
                PH_EQWS: emit = ws ? CK_NONE : CK_ARG;
                PH_QWS:  emit = ws ? CK_NONE : CK_ARG;
                PH_ARGS: emit = is_eol(c) ? CK_NONE : CK_ARG;
                default: emit = CK_NONE;
            endcase
        end

        err = upd_failed || (upd_phase == PH_A) || (upd_phase == PH_T)
              || (upd_phase == PH_WS1) || ((upd_phase == PH_NAME) && (upd_count == '0));

        res.char_kind  = emit;
        res.char_value = (emit != CK_NONE) ? c : 8'h00;
        res.done_res   = item.last;
        res.status     = item.last && err;
        res.cmd_class  = (item.last && !err) ? upd_kind : CMD_EXEC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_A;
            kind_reg   <= CMD_EXEC;
            count_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            count_reg  <= count_next;
            failed_reg <= failed_next;
        end
    end

    `ATCLP_ASSERT(a_line_end_clears, step && item.last |=> line_idle, "line state not cleared")
    `ATCLP_ASSERT(a_failed_silent, step && failed_reg |-> res.char_kind == CK_NONE, "failed emit")
    `ATCLP_ASSERT_NEVER(a_err_type, step && res.status && res.cmd_class != CMD_EXEC, "bad type")
    `ATCLP_ASSERT(a_count_bound, count_reg <= CNT_W'(NAME_LIMIT), "count overflow")

endmodule

// ===== design/atclp_out_stage.sv =====
// Result register of the AT command line parser, with its valid/stall control.
// Depends on atclp_pkg.
module atclp_out_stage
    import atclp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_vld,
    input  out_item_t res,
    output link_t     link,
    output logic      valid,
    input  logic      stall,
    output out_item_t data
);

    logic      vld_reg, vld_next;
    out_item_t data_reg;

    assign link.blocked = vld_reg && stall;
    assign link.move    = src_vld && !link.blocked;

    always_comb
    begin
        vld_next = vld_reg;
        if (link.move)
        begin
            vld_next = 1'b1;
        end
        else if (!stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link.move)
        begin
            data_reg <= res;
        end
    end

    assign valid = vld_reg;
    assign data  = data_reg;

endmodule

// ===== design/at_command_line_parser.sv =====
// AT command line parser: one character transaction in, one result transaction out.
// An accepted character passes through the input register and then the result register.
// Throughput is one character per cycle while the output is not stalled; the line state advances in a single step.
// The input register refills while a finished result waits on a stalled output.
// Reset (rst_n low, asynchronous) empties both registers and returns the line
// state to "expect the first A" with an empty name and exec type.
module at_command_line_parser
    import atclp_pkg::*;
#(
    parameter int NAME_LIMIT = NAME_LIMIT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  in_item_t  char_data,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_data
);

    // Pipeline control between the result register and the stages ahead of it.
    link_t     link;
    // Character held in the input register and its valid flag.
    logic      in_vld;
    in_item_t  in_item;
    // Result computed combinationally from the held character and line state.
    out_item_t step_res;

    // Stage one: registers an accepted character transaction.
    atclp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (char_valid),
        .stall    (char_stall),
        .data     (char_data),
        .link     (link),
        .vld_reg  (in_vld),
        .item_reg (in_item)
    );

    // The line state machine advances exactly when the held character moves
    // into the result register, so every character is parsed once, in order.
    atclp_parser #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (link.move),
        .item  (in_item),
        .res   (step_res)
    );

    // Stage two: holds the result transaction until the consumer takes it.
    atclp_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .src_vld (in_vld),
        .res     (step_res),
        .link    (link),
        .valid   (res_valid),
        .stall   (res_stall),
        .data    (res_data)
    );

endmodule
